// ===== design/glos_pkg.sv =====
// shared constants for the grid line-of-sight checker
package glos_pkg;

  // default grid geometry
  localparam int GRID_SIDE_BITS_DEF = 6;
  localparam int FRACTION_BITS_DEF  = 8;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

endpackage

// ===== design/glos_ram.sv =====
// generic single-write, single-read ram with registered read data
module glos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/grid_line_of_sight_check_top.sv =====
// Grid line-of-sight checker: a one-bit passability map of a square grid held in a
// single-port-read ram of 2^(2*GRID_SIDE_BITS) bits (4096 at the default), and a walker
// that visits every cell a fixed-point segment crosses, stopping at the first blocked
// cell. After reset the block sweeps the whole map to blocked, one entry a cycle, so in
// ready stays low until the sweep is done. A write item passes through the finish state
// into the output register. A check item takes four setup steps (latch, deltas, cross
// products, difference), then walks the visited cells with one map read each, then
// moves into the output register; a walk visits at most 2 * 2^GRID_SIDE_BITS cells and
// stops at the end cell, at the first blocked cell or on leaving the grid. The single map
// read port, one cell a cycle, sets the walk rate. One item is in work at a time; a new
// item is taken while the previous result still waits in the output register.
module grid_line_of_sight_check_top
  import glos_pkg::*;
#(
  parameter int GRID_SIDE_BITS = GRID_SIDE_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    opcode,
  input  logic [GRID_SIDE_BITS-1:0]               cell_x,
  input  logic [GRID_SIDE_BITS-1:0]               cell_y,
  input  logic                                    cell_passable,
  input  logic [GRID_SIDE_BITS+FRACTION_BITS-1:0] start_x,
  input  logic [GRID_SIDE_BITS+FRACTION_BITS-1:0] start_y,
  input  logic [GRID_SIDE_BITS+FRACTION_BITS-1:0] end_x,
  input  logic [GRID_SIDE_BITS+FRACTION_BITS-1:0] end_y,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    line_clear
);

  localparam int GSB   = GRID_SIDE_BITS;
  localparam int FB    = FRACTION_BITS;
  localparam int CW    = GSB + FB;          // coordinate width
  localparam int AW    = 2 * GSB;           // map address width
  localparam int DEPTH = 1 << AW;
  localparam int GW    = FB + 1;            // first boundary gap width
  localparam int PW    = GW + CW;           // cross product width
  localparam int DW    = 2 * CW + 3;        // running cross difference width
  localparam int XW    = GSB + 2;           // walk position, room to leave the grid
  localparam int NW    = GSB + 2;           // visited cell count
  localparam int WALK_CAP = 2 << GSB;

  localparam logic [CW-1:0] FRAC_MASK = CW'((1 << FB) - 1);
  localparam logic [GW-1:0] UNIT_LEN  = GW'(1 << FB);
  localparam logic [NW-1:0] LAST_CNT  = NW'(WALK_CAP - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SETUP  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIFF   = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]    state;
  logic [AW-1:0] clear_addr;

  // latched check endpoints
  logic [CW-1:0] x0, y0, x1, y1;

  // walk setup
  logic          neg_x, neg_y, zero_x, zero_y;
  logic [CW-1:0] ax, ay;
  logic [GW-1:0] gap_x, gap_y;
  logic [PW-1:0] prod_x, prod_y;
  logic [DW-1:0] cross_diff;

  // walk position
  logic [XW-1:0]  x, y;
  logic [GSB-1:0] ex, ey;
  logic [NW-1:0]  count;

  // cell whose map read is in flight
  logic p_valid, p_out, p_end, p_last;
  logic result;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic in_acc;
  logic step_x, cur_out, cur_end, walk_stop;
  logic [CW-1:0] frac_x, frac_y;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // map writes come from the clearing sweep or from write items
  assign ram_we    = (state == S_CLEAR) || (in_acc && opcode == OP_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? clear_addr : {cell_y, cell_x};
  assign ram_wdata = (state == S_CLEAR) ? 1'b0 : cell_passable;
  assign ram_raddr = {y[GSB-1:0], x[GSB-1:0]};

  glos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fraction parts of the start point
  assign frac_x = x0 & FRAC_MASK;
  assign frac_y = y0 & FRAC_MASK;

  // walk step decision and current cell tests
  assign step_x  = !zero_x && (zero_y || cross_diff[DW-1]);
  assign cur_out = (x[XW-1:GSB] != '0) || (y[XW-1:GSB] != '0);
  assign cur_end = (x == {2'b00, ex}) && (y == {2'b00, ey});
  assign walk_stop = p_valid && (p_out || !ram_rdata || p_end || p_last);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      p_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state <= (opcode == OP_WRITE) ? S_FINISH : S_SETUP;
          end
        end
        S_SETUP: state <= S_MUL;
        S_MUL:   state <= S_DIFF;
        S_DIFF: begin
          state   <= S_WALK;
          p_valid <= 1'b0;
        end
        S_WALK: begin
          if (walk_stop) begin
            state <= S_FINISH;
          end else begin
            p_valid <= 1'b1;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        result <= 1'b1;
        x0 <= start_x;
        y0 <= start_y;
        x1 <= end_x;
        y1 <= end_y;
      end
      S_SETUP: begin
        zero_x <= (x1 == x0);
        zero_y <= (y1 == y0);
        neg_x  <= (x1 < x0);
        neg_y  <= (y1 < y0);
        ax     <= (x1 < x0) ? x0 - x1 : x1 - x0;
        ay     <= (y1 < y0) ? y0 - y1 : y1 - y0;
        gap_x  <= (x1 == x0) ? '0 : (x1 < x0) ? GW'(frac_x) : UNIT_LEN - GW'(frac_x);
        gap_y  <= (y1 == y0) ? '0 : (y1 < y0) ? GW'(frac_y) : UNIT_LEN - GW'(frac_y);
        x      <= XW'(x0 >> FB);
        y      <= XW'(y0 >> FB);
        ex     <= GSB'(x1 >> FB);
        ey     <= GSB'(y1 >> FB);
      end
      S_MUL: begin
        prod_x <= PW'(gap_x) * PW'(ay);
        prod_y <= PW'(gap_y) * PW'(ax);
      end
      S_DIFF: begin
        cross_diff <= DW'(prod_x) - DW'(prod_y);
        count      <= '0;
      end
      S_WALK: begin
        if (walk_stop) begin
          result <= !p_out && ram_rdata && p_end;
        end else begin
          p_out  <= cur_out;
          p_end  <= cur_end;
          p_last <= (count == LAST_CNT);
          count  <= count + 1'b1;
          if (step_x) begin
            x          <= neg_x ? x - 1'b1 : x + 1'b1;
            cross_diff <= cross_diff + (DW'(ay) << FB);
          end else begin
            y          <= neg_y ? y - 1'b1 : y + 1'b1;
            cross_diff <= cross_diff - (DW'(ax) << FB);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      line_clear <= result;
    end
  end

endmodule

// ===== design/glos_checker.sv =====
// port-level checks for the grid line-of-sight checker, bound to the top level
module glos_checker
  import glos_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic opcode,
  input logic out_valid,
  input logic out_ready,
  input logic line_clear
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_clear))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // map clearing after reset keeps the block closed
  a_reset_closed: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready && !out_valid)
    else $error("block open right after reset");

  // a write item is acknowledged, with line_clear set, after the finish state when the output is free
  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_WRITE && !out_valid |=> ##1 out_valid && line_clear)
    else $error("write item not acknowledged");

endmodule

bind grid_line_of_sight_check_top glos_checker u_glos_checker (.*);
